// ----- src/prescaled_countdown_timer_unit_assert.svh -----
// Assertion macros shared by the timer RTL.
`ifndef PRESCALED_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define PRESCALED_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PCTU_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pctu assertion failed");

// Next-cycle implication.
`define PCTU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pctu assertion failed");

`endif

// ----- src/pctu_pkg.sv -----
package pctu_pkg;

  localparam int PRESCALE_COUNT_WIDTH = 24;
  localparam int TickWidth = 16;
  localparam int PrsMaxShift = 7;
  localparam int ShiftedMin = TickWidth + PrsMaxShift;
  localparam int ShiftedWidth =
    (PRESCALE_COUNT_WIDTH > ShiftedMin) ? PRESCALE_COUNT_WIDTH : ShiftedMin;
  localparam int CfgIndexWidth = 2;

  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqRead  = 2'd1,
    ReqWrite = 2'd2,
    ReqNop   = 2'd3
  } req_type_t;

  localparam logic [5:0] RegIrqEnable = 6'd0;
  localparam logic [5:0] RegIrqStatus = 6'd1;
  localparam logic [5:0] RegControl   = 6'd4;
  localparam logic [5:0] RegInterval  = 6'd5;
  localparam logic [5:0] RegCurrent   = 6'd6;

  localparam logic [CfgIndexWidth-1:0] CfgSlowTicks = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgFastTicks = CfgIndexWidth'(1);

  localparam logic [15:0] SlowTicksReset = 16'd18750;
  localparam logic [15:0] FastTicksReset = 16'd25;

  // control word bit positions
  localparam int CtlEnable   = 0;
  localparam int CtlReload   = 1;
  localparam int CtlClkLo    = 2;
  localparam int CtlClkHi    = 3;
  localparam int CtlPrsLo    = 4;
  localparam int CtlPrsHi    = 6;
  localparam int CtlSingle   = 7;
  localparam logic [2:0] StatusMask = 3'h7;

  typedef struct packed {
    logic        fire;
    req_type_t   kind;
    logic [5:0]  index;
    logic [31:0] data;
    logic [3:0]  be;
  } pctu_req_t;

  typedef struct packed {
    logic                     fire;
    logic [CfgIndexWidth-1:0] index;
    logic [15:0]              data;
  } pctu_cfg_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        irq_pending;
  } pctu_rsp_t;

  function automatic logic [31:0] merge_bytes(logic [31:0] old, logic [31:0] data,
                                              logic [3:0] be);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      if (be[i]) m[8*i +: 8] = 8'hFF;
    end
    return (old & ~m) | (data & m);
  endfunction

endpackage

// ----- src/pctu_core.sv -----
module pctu_core (
  input  logic                clk,
  input  logic                rst,
  input  pctu_pkg::pctu_req_t req,
  input  pctu_pkg::pctu_cfg_t cfg,
  output pctu_pkg::pctu_rsp_t rsp
);
  import pctu_pkg::*;
  `include "prescaled_countdown_timer_unit_assert.svh"

  logic [15:0] slow_ticks;
  logic [15:0] fast_ticks;
  logic [31:0] irq_enable, irq_enable_next;
  logic [2:0]  irq_status, irq_status_next;
  logic [31:0] control, control_next;
  logic [31:0] interval, interval_next;
  logic [31:0] current, current_next;
  logic [PRESCALE_COUNT_WIDTH-1:0] prescale_count, prescale_count_next;
  logic [PRESCALE_COUNT_WIDTH-1:0] prescale_reload, prescale_reload_next;

  logic [31:0] cur_dec;
  logic [31:0] ctl_merged;
  logic [15:0] base_ticks;
  logic [ShiftedWidth-1:0] shifted;
  logic [PRESCALE_COUNT_WIDTH-1:0] reload_calc;
  logic implemented;

  assign cur_dec    = current - 32'd1;
  assign ctl_merged = merge_bytes(control, req.data, req.be);
  assign base_ticks = (ctl_merged[CtlClkHi:CtlClkLo] == 2'b00) ? slow_ticks : fast_ticks;
  assign shifted    = ShiftedWidth'(base_ticks) << ctl_merged[CtlPrsHi:CtlPrsLo];
  // saturate when the shifted count does not fit the prescaler
  assign reload_calc = ((shifted >> PRESCALE_COUNT_WIDTH) != '0) ? '1
                     : shifted[PRESCALE_COUNT_WIDTH-1:0];

  always_comb begin
    case (req.index)
      RegIrqEnable, RegIrqStatus, RegControl, RegInterval, RegCurrent: implemented = 1'b1;
      default: implemented = 1'b0;
    endcase
  end

  always_comb begin
    irq_enable_next      = irq_enable;
    irq_status_next      = irq_status;
    control_next         = control;
    interval_next        = interval;
    current_next         = current;
    prescale_count_next  = prescale_count;
    prescale_reload_next = prescale_reload;
    rsp.read_data        = '0;
    if (req.fire) begin
      case (req.kind)
        ReqTick: begin
          if (control[CtlEnable]) begin
            if (prescale_count > PRESCALE_COUNT_WIDTH'(1)) begin
              prescale_count_next = prescale_count - PRESCALE_COUNT_WIDTH'(1);
            end else begin
              if (cur_dec == '0 || cur_dec[31]) begin
                current_next = interval;
                if (irq_enable[0]) irq_status_next[0] = 1'b1;
                if (control[CtlSingle]) control_next[CtlEnable] = 1'b0;
              end else begin
                current_next = cur_dec;
              end
              prescale_count_next = prescale_reload;
            end
          end
        end
        ReqRead: begin
          case (req.index)
            RegIrqEnable: rsp.read_data = irq_enable;
            RegIrqStatus: rsp.read_data = {29'd0, irq_status & StatusMask};
            RegControl:   rsp.read_data = control;
            RegInterval:  rsp.read_data = interval;
            RegCurrent:   rsp.read_data = current;
            default:      rsp.read_data = '0;
          endcase
        end
        ReqWrite: begin
          case (req.index)
            RegIrqEnable: irq_enable_next = merge_bytes(irq_enable, req.data, req.be);
            RegIrqStatus: begin
              // write-one-to-clear, gated by byte 0
              if (req.be[0]) irq_status_next = irq_status & ~(req.data[2:0] & StatusMask);
            end
            RegControl: begin
              control_next = ctl_merged;
              if (ctl_merged[CtlEnable] && !control[CtlEnable]) begin
                if (current == '0 || ctl_merged[CtlReload]) current_next = interval;
                control_next[CtlReload] = 1'b0;
              end
              prescale_reload_next = reload_calc;
              prescale_count_next  = reload_calc;
            end
            RegInterval: interval_next = merge_bytes(interval, req.data, req.be);
            RegCurrent:  current_next  = merge_bytes(current, req.data, req.be);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    rsp.access_ok   = (req.kind == ReqRead || req.kind == ReqWrite) && implemented;
    rsp.irq_pending = irq_status_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_ticks      <= SlowTicksReset;
      fast_ticks      <= FastTicksReset;
      irq_enable      <= '0;
      irq_status      <= '0;
      control         <= '0;
      interval        <= '0;
      current         <= '0;
      prescale_count  <= '0;
      prescale_reload <= '0;
    end else begin
      if (cfg.fire && cfg.index == CfgSlowTicks) slow_ticks <= cfg.data;
      if (cfg.fire && cfg.index == CfgFastTicks) fast_ticks <= cfg.data;
      irq_enable      <= irq_enable_next;
      irq_status      <= irq_status_next;
      control         <= control_next;
      interval        <= interval_next;
      current         <= current_next;
      prescale_count  <= prescale_count_next;
      prescale_reload <= prescale_reload_next;
    end
  end

  `PCTU_ASSERT_IMPL(a_count_le_reload, 1'b1, prescale_count <= prescale_reload)
  `PCTU_ASSERT_IMPL(a_enable_by_write, $rose(control[CtlEnable]),
                    $past(req.fire && req.kind == ReqWrite && req.index == RegControl))
  `PCTU_ASSERT_IMPL(a_status_needs_ie, $rose(irq_status[0]), $past(irq_enable[0]))

endmodule

// ----- src/prescaled_countdown_timer_unit.sv -----
// channel   signals                                         role
// in        in_valid/in_ready, req_type..byte_enable        tick, read, write or no-op
// out       out_valid/out_ready, read_data..irq_pending     one result per item
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data        tick source counts
//
// One item per cycle while in_ready is high; its result appears in the output register the next cycle.
// All state but the tick source counts updates in the cycle the input transfer happens; one register stage.
// in_ready drops only while a result waits and out_ready is low.
// cfg_ready is always high. Synchronous reset clears the timer state and reloads the tick source counts.
module prescaled_countdown_timer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [5:0]                          reg_index,
  input  logic [31:0]                         write_data,
  input  logic [3:0]                          byte_enable,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         read_data,
  output logic                                access_ok,
  output logic                                irq_pending,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pctu_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [15:0]                         cfg_data
);
  import pctu_pkg::*;
  `include "prescaled_countdown_timer_unit_assert.svh"

  pctu_req_t req;
  pctu_cfg_t cfg;
  pctu_rsp_t rsp;
  logic      in_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign req.fire  = in_fire;
  assign req.kind  = req_type_t'(req_type);
  assign req.index = reg_index;
  assign req.data  = write_data;
  assign req.be    = byte_enable;

  assign cfg.fire  = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  pctu_core u_core (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cfg (cfg),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data   <= rsp.read_data;
      access_ok   <= rsp.access_ok;
      irq_pending <= rsp.irq_pending;
    end
  end

  `PCTU_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid)
  `PCTU_ASSERT_NEXT(a_tick_no_access, in_fire && req_type == ReqTick,
                    read_data == '0 && !access_ok)
  `PCTU_ASSERT_NEXT(a_bad_index_read, in_fire && req_type == ReqRead &&
                    reg_index != RegIrqEnable && reg_index != RegIrqStatus &&
                    reg_index != RegControl && reg_index != RegInterval &&
                    reg_index != RegCurrent, read_data == '0 && !access_ok)

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pctu_pkg::*;

  typedef struct {
    req_type_t   kind;
    logic [5:0]  idx;
    logic [31:0] data;
    logic [3:0]  be;
  } bus_op_t;

  typedef struct {
    req_type_t   kind;
    logic [5:0]  idx;
    logic [31:0] data;
    logic [3:0]  be;
    bit          typed;
    logic [31:0] rd;
    logic        ok;
    logic        irq;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam int PHASE_ITEMS = 433;
  localparam logic [63:0] PCOUNT_MAX = (64'd1 << PRESCALE_COUNT_WIDTH) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = ReqNop;
  logic [5:0]  reg_index = '0;
  logic [31:0] write_data = '0;
  logic [3:0]  byte_enable = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        access_ok;
  logic        irq_pending;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // timer shadow state
  logic [15:0] m_slow, m_fast;
  logic [31:0] m_irq_en, m_ctl, m_interval, m_current;
  logic [2:0]  m_status;
  logic [PRESCALE_COUNT_WIDTH-1:0] m_pcount, m_preload;

  pctu_rsp_t pending_rsp [$];
  int err_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  dir_row_t dir_rows [DIR_ROWS];

  prescaled_countdown_timer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .reg_index  (reg_index),
    .write_data (write_data),
    .byte_enable(byte_enable),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .access_ok  (access_ok),
    .irq_pending(irq_pending),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] lane_merge(logic [31:0] old, logic [31:0] nu,
                                             logic [3:0] be);
    logic [31:0] keep;
    keep = {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
    return (old & ~keep) | (nu & keep);
  endfunction

  function automatic void clear_timer_model();
    m_slow = SlowTicksReset;
    m_fast = FastTicksReset;
    m_irq_en = '0;
    m_status = '0;
    m_ctl = '0;
    m_interval = '0;
    m_current = '0;
    m_pcount = '0;
    m_preload = '0;
  endfunction

  function automatic void timer_tick();
    if (!m_ctl[CtlEnable]) return;
    if (m_pcount > 1) begin
      m_pcount = m_pcount - 1'b1;
      return;
    end
    m_current = m_current - 32'd1;
    if (m_current == '0 || m_current[31]) begin
      m_current = m_interval;
      if (m_irq_en[0]) m_status[0] = 1'b1;
      if (m_ctl[CtlSingle]) m_ctl[CtlEnable] = 1'b0;
    end
    m_pcount = m_preload;
  endfunction

  function automatic void control_update(logic [31:0] data, logic [3:0] be);
    logic        was_on;
    logic [63:0] wide;
    logic [15:0] base;
    was_on = m_ctl[CtlEnable];
    m_ctl = lane_merge(m_ctl, data, be);
    if (m_ctl[CtlEnable] && !was_on) begin
      if (m_current == '0 || m_ctl[CtlReload]) m_current = m_interval;
      m_ctl[CtlReload] = 1'b0;
    end
    base = (m_ctl[CtlClkHi:CtlClkLo] == 2'd0) ? m_slow : m_fast;
    wide = {48'd0, base} << m_ctl[CtlPrsHi:CtlPrsLo];
    if (wide > PCOUNT_MAX) wide = PCOUNT_MAX;
    m_preload = wide[PRESCALE_COUNT_WIDTH-1:0];
    m_pcount = m_preload;
  endfunction

  // advances the shadow state by one item and returns its result
  function automatic pctu_rsp_t timer_predict(bus_op_t op);
    pctu_rsp_t rsp;
    logic      known;
    rsp = '0;
    known = (op.idx == RegIrqEnable) || (op.idx == RegIrqStatus) ||
            (op.idx == RegControl) || (op.idx == RegInterval) || (op.idx == RegCurrent);
    case (op.kind)
      ReqTick: timer_tick();
      ReqRead: begin
        rsp.access_ok = known;
        case (op.idx)
          RegIrqEnable: rsp.read_data = m_irq_en;
          RegIrqStatus: rsp.read_data = {29'd0, m_status & StatusMask};
          RegControl:   rsp.read_data = m_ctl;
          RegInterval:  rsp.read_data = m_interval;
          RegCurrent:   rsp.read_data = m_current;
          default:      rsp.read_data = '0;
        endcase
      end
      ReqWrite: begin
        rsp.access_ok = known;
        case (op.idx)
          RegIrqEnable: m_irq_en = lane_merge(m_irq_en, op.data, op.be);
          RegIrqStatus: if (op.be[0]) m_status = m_status & ~(op.data[2:0] & StatusMask);
          RegControl:   control_update(op.data, op.be);
          RegInterval:  m_interval = lane_merge(m_interval, op.data, op.be);
          RegCurrent:   m_current = lane_merge(m_current, op.data, op.be);
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.irq_pending = m_status[0];
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : rsp_check
    pctu_rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result", read_data, '0);
        end else begin
          want = pending_rsp.pop_front();
          if (read_data !== want.read_data)
            report_mismatch("read_data", read_data, want.read_data);
          if (access_ok !== want.access_ok)
            report_mismatch("access_ok", {31'd0, access_ok}, {31'd0, want.access_ok});
          if (irq_pending !== want.irq_pending)
            report_mismatch("irq_pending", {31'd0, irq_pending}, {31'd0, want.irq_pending});
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic send_op(bus_op_t op, bit typed, pctu_rsp_t typed_rsp);
    pctu_rsp_t rsp;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid    <= 1'b1;
    req_type    <= op.kind;
    reg_index   <= op.idx;
    write_data  <= op.data;
    byte_enable <= op.be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp = timer_predict(op);
    pending_rsp.push_back(typed ? typed_rsp : rsp);
  endtask

  // wait for all results, then let the output stage empty
  task automatic settle();
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_ticks(logic [15:0] slow, logic [15:0] fast);
    cfg_valid <= 1'b1;
    cfg_index <= CfgSlowTicks;
    cfg_data  <= slow;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_slow = slow;
    cfg_index <= CfgFastTicks;
    cfg_data  <= fast;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_fast = fast;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bus_op_t random_op();
    bus_op_t op;
    int      pick;
    logic [5:0] common_regs [8];
    common_regs = '{RegIrqEnable, RegIrqStatus, RegControl, RegControl,
                    RegInterval, RegInterval, RegCurrent, RegCurrent};
    pick = $urandom_range(0, 99);
    if (pick < 50)      op.kind = ReqTick;
    else if (pick < 70) op.kind = ReqRead;
    else if (pick < 95) op.kind = ReqWrite;
    else                op.kind = ReqNop;
    pick = $urandom_range(0, 9);
    op.idx = (pick < 8) ? common_regs[pick] : 6'($urandom_range(0, 63));
    op.data = $urandom();
    op.be = ($urandom_range(0, 99) < 70) ? 4'hF : 4'($urandom_range(0, 15));
    if (op.kind == ReqWrite) begin
      case (op.idx)
        RegControl: if ($urandom_range(0, 99) < 80) begin
          op.data[CtlEnable] = ($urandom_range(0, 99) < 75);
          op.data[CtlPrsHi:CtlPrsLo] =
            ($urandom_range(0, 99) < 70) ? 3'd0 : 3'($urandom_range(0, 7));
        end
        RegInterval, RegCurrent:
          if ($urandom_range(0, 99) < 75) op.data = $urandom_range(0, 12);
        RegIrqEnable: op.data[0] = ($urandom_range(0, 99) < 70);
        default: ;
      endcase
    end
    return op;
  endfunction

  initial begin : stimulus
    bus_op_t   op;
    pctu_rsp_t rsp;
    dir_rows = '{
      '{ReqRead,  RegControl,   32'h0,        4'hF, 1'b1, 32'h0,        1'b1, 1'b0},
      '{ReqRead,  RegCurrent,   32'hFFFF_FFFF, 4'h0, 1'b1, 32'h0,       1'b1, 1'b0},
      '{ReqRead,  6'd63,        32'h0,        4'hF, 1'b1, 32'h0,        1'b0, 1'b0},
      '{ReqWrite, 6'd2,         32'hFFFF_FFFF, 4'hF, 1'b1, 32'h0,       1'b0, 1'b0},
      '{ReqNop,   RegControl,   32'hFFFF_FFFF, 4'hF, 1'b1, 32'h0,       1'b0, 1'b0},
      '{ReqWrite, RegIrqEnable, 32'hFFFF_FFFF, 4'hF, 1'b1, 32'h0,       1'b1, 1'b0},
      '{ReqRead,  RegIrqEnable, 32'h0,        4'h0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
      '{ReqWrite, RegInterval,  32'h2,        4'hF, 1'b0, 32'h0, 1'b0, 1'b0},
      // enable in single mode, prescaler fires every tick
      '{ReqWrite, RegControl,   32'h81,       4'hF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqTick,  6'd0,         32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqTick,  6'd0,         32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqRead,  RegControl,   32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqRead,  RegIrqStatus, 32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqTick,  6'd0,         32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      // status clears only on ones in an enabled low byte
      '{ReqWrite, RegIrqStatus, 32'h0,        4'h1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqWrite, RegIrqStatus, 32'h7,        4'hE, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqWrite, RegIrqStatus, 32'h7,        4'h1, 1'b0, 32'h0, 1'b0, 1'b0},
      // most negative count wraps without reload
      '{ReqWrite, RegCurrent,   32'h8000_0000, 4'hF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqWrite, RegControl,   32'h1,        4'hF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqTick,  6'd0,         32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqRead,  RegCurrent,   32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      // reload bit held across a falling enable; the next rising write sets it again and reloads
      '{ReqWrite, RegControl,   32'h2,        4'hF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqRead,  RegControl,   32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqWrite, RegControl,   32'h73,       4'h1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqTick,  6'd0,         32'h0,        4'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ReqRead,  RegCurrent,   32'hFFFF_FFFF, 4'h0, 1'b0, 32'h0, 1'b0, 1'b0}
    };
    clear_timer_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 34;
    rcv_idle_pct = 70;
    program_ticks(16'd1, 16'd3);
    foreach (dir_rows[i]) begin
      op.kind = dir_rows[i].kind;
      op.idx  = dir_rows[i].idx;
      op.data = dir_rows[i].data;
      op.be   = dir_rows[i].be;
      rsp.read_data   = dir_rows[i].rd;
      rsp.access_ok   = dir_rows[i].ok;
      rsp.irq_pending = dir_rows[i].irq;
      send_op(op, dir_rows[i].typed, rsp);
    end
    for (int n = 0; n < PHASE_ITEMS; n++) send_op(random_op(), 1'b0, '0);
    in_valid <= 1'b0;
    settle();

    snd_idle_pct = 70;
    rcv_idle_pct = 34;
    program_ticks(16'hFFFF, 16'd1);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) begin
        in_valid <= 1'b0;
        settle();
      end
      send_op(random_op(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    settle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    program_ticks(16'd2, 16'hFFFF);
    for (int n = 0; n < PHASE_ITEMS; n++) send_op(random_op(), 1'b0, '0);
    in_valid <= 1'b0;
    settle();

    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
